/* hdl/wos_pkg.sv */
// wos_pkg: types, codes and sizes shared by the word operand stack.
// No dependencies; imported by every module of the block.
package wos_pkg;

  // fixed field widths of the beats
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned ENTRY_W   = 4 * WORD_W;
  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned ERR_W     = 3;
  localparam int unsigned DEPTH_W   = 11;

  // default stack size
  localparam int unsigned STACK_DEPTH_DEF = 1024;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH       = 3'd0,
    OP_POP        = 3'd1,
    OP_POP_ADDR   = 3'd2,
    OP_POP_U64    = 3'd3,
    OP_POP_AMOUNT = 3'd4,
    OP_SWAP       = 3'd5,
    OP_DUP        = 3'd6,
    OP_NONE       = 3'd7
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 3'd0,
    ERR_UNDER = 3'd1,
    ERR_OVER  = 3'd2,
    ERR_INDEX = 3'd3,
    ERR_LARGE = 3'd4
  } err_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [WORD_W-1:0]   push_word0;
    logic [WORD_W-1:0]   push_word1;
    logic [WORD_W-1:0]   push_word2;
    logic [WORD_W-1:0]   push_word3;
    logic [POS_W-1:0]    position;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  out_word0;
    logic [WORD_W-1:0]  out_word1;
    logic [WORD_W-1:0]  out_word2;
    logic [WORD_W-1:0]  out_word3;
    logic [ERR_W-1:0]   error_code;
    logic [DEPTH_W-1:0] depth;
  } out_item_t;

endpackage

/* hdl/wos_mem.sv */
// wos_mem: stack entry storage, one write port and two registered read ports.
// Depends on wos_pkg for the entry width.
module wos_mem #(
  parameter int unsigned DEPTH = wos_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_b,
  output logic [wos_pkg::ENTRY_W-1:0]   rd_data_a,
  output logic [wos_pkg::ENTRY_W-1:0]   rd_data_b,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [wos_pkg::ENTRY_W-1:0]   wr_data
);
  import wos_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, registered; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* hdl/wos_popfmt.sv */
// wos_popfmt: shapes a popped entry per pop flavor and flags values too large.
// Depends on wos_pkg for opcodes and widths.
module wos_popfmt (
  input  wos_pkg::op_t                  op,
  input  logic [wos_pkg::ENTRY_W-1:0]   word,
  output logic [wos_pkg::ENTRY_W-1:0]   value,
  output logic                          too_large
);
  import wos_pkg::*;

  localparam int unsigned ADDR_BITS   = 160;
  localparam int unsigned AMOUNT_BITS = 62;

  always_comb begin
    value     = word;
    too_large = 1'b0;
    case (op)
      // address: keep the low 160 bits
      OP_POP_ADDR: begin
        value = {{(ENTRY_W-ADDR_BITS){1'b0}}, word[ADDR_BITS-1:0]};
      end
      // u64: anything above bit 63 is an error
      OP_POP_U64: begin
        value     = {{(ENTRY_W-WORD_W){1'b0}}, word[WORD_W-1:0]};
        too_large = |word[ENTRY_W-1:WORD_W];
      end
      // amount: limit is 2^62-1
      OP_POP_AMOUNT: begin
        value     = {{(ENTRY_W-WORD_W){1'b0}}, word[WORD_W-1:0]};
        too_large = |word[ENTRY_W-1:AMOUNT_BITS];
      end
      default: begin
        value     = word;
        too_large = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/word_operand_stack.sv */
// word_operand_stack: 256-bit operand stack. The result strobe is high in the cycle after
// the execute cycle, or after the second write state for a swap with a legal position;
// busy is high from the accepting edge up to the strobe cycle, so no beat is taken while
// one is in flight; the pace is set by the registered memory read and, for a swap, by the
// single write port. The receiver cannot stall. Reset clears the depth and control
// state only; entry memory is not cleared and needs no clearing pass.
module word_operand_stack #(
  parameter int unsigned STACK_DEPTH = wos_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  wos_pkg::in_item_t   in_item,
  output logic                out_valid,
  output wos_pkg::out_item_t  out_item
);
  import wos_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_SWAP2 = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  op_t                op_r;
  logic [POS_W-1:0]   pos_r;
  logic [ENTRY_W-1:0] push_r;
  logic [AW-1:0]      top_addr_r, oth_addr_r;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               accept;
  logic [PW-1:0]      top_full, oth_full;
  logic [AW-1:0]      rd_addr_a, rd_addr_b;
  logic [ENTRY_W-1:0] rd_data_a, rd_data_b;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [ENTRY_W-1:0] mem_wd;
  logic [ENTRY_W-1:0] pop_value;
  logic               pop_large;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // read addresses: top and top minus position, issued with the accepted beat.
  // All writes of an item finish before the next beat is accepted, so no forwarding.
  assign top_full  = PW'(count_r) - PW'(1);
  assign oth_full  = top_full - PW'(in_item.position);
  assign rd_addr_a = top_full[AW-1:0];
  assign rd_addr_b = oth_full[AW-1:0];

  wos_mem #(
    .DEPTH (STACK_DEPTH)
  ) u_mem (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (mem_we),
    .wr_addr   (mem_wa),
    .wr_data   (mem_wd)
  );

  wos_popfmt u_popfmt (
    .op        (op_r),
    .word      (rd_data_a),
    .value     (pop_value),
    .too_large (pop_large)
  );

  // sequencer and result
  always_comb begin
    logic               pos_bad;
    logic               full;
    logic [ENTRY_W-1:0] val;
    err_t               err;

    pos_bad       = PW'(pos_r) >= PW'(count_r);
    full          = (count_r == CW'(STACK_DEPTH));
    val           = '0;
    err           = ERR_OK;
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = top_addr_r;
    mem_wd        = rd_data_b;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        unique case (op_r) inside
          OP_PUSH: begin
            if (full) begin
              err = ERR_OVER;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = AW'(count_r);
              mem_wd    = push_r;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_POP, OP_POP_ADDR, OP_POP_U64, OP_POP_AMOUNT: begin
            if (count_r == '0) begin
              err = ERR_UNDER;
            end else begin
              count_nxt = count_r - CW'(1);
              val       = pop_value;
              err       = pop_large ? ERR_LARGE : ERR_OK;
            end
          end
          OP_SWAP: begin
            if (pos_bad) begin
              err = ERR_INDEX;
            end else begin
              // top takes the other entry now, other takes the old top next
              mem_we        = 1'b1;
              mem_wa        = top_addr_r;
              mem_wd        = rd_data_b;
              state_nxt     = S_SWAP2;
              out_valid_nxt = 1'b0;
            end
          end
          OP_DUP: begin
            if (pos_bad) begin
              err = ERR_INDEX;
            end else if (full) begin
              err = ERR_OVER;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = AW'(count_r);
              mem_wd    = rd_data_b;
              count_nxt = count_r + CW'(1);
            end
          end
          default: begin
            err = ERR_OK;
          end
        endcase
        out_nxt.out_word0  = val[WORD_W-1:0];
        out_nxt.out_word1  = val[2*WORD_W-1:WORD_W];
        out_nxt.out_word2  = val[3*WORD_W-1:2*WORD_W];
        out_nxt.out_word3  = val[4*WORD_W-1:3*WORD_W];
        out_nxt.error_code = err;
        out_nxt.depth      = DEPTH_W'(count_nxt);
      end
      S_SWAP2: begin
        mem_we        = 1'b1;
        mem_wa        = oth_addr_r;
        mem_wd        = rd_data_a;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // beat capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= op_t'(in_item.opcode);
      pos_r      <= in_item.position;
      push_r     <= {in_item.push_word3, in_item.push_word2,
                     in_item.push_word1, in_item.push_word0};
      top_addr_r <= rd_addr_a;
      oth_addr_r <= rd_addr_b;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // checks
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on two cycles in a row");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC) && busy)
    else $error("accepted beat did not enter execution");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_wa) < int'(STACK_DEPTH)))
    else $error("entry write outside the stack");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.error_code <= ERR_LARGE))
    else $error("undefined error code on result");

endmodule

/* bench/word_operand_stack_checker.sv */
// Result checker for the word operand stack: mirrors the stack contents and depth,
// predicts one result per accepted beat and compares every strobed result in order.
// Depends on wos_pkg for the beat structs, opcodes and error codes.
module word_operand_stack_checker #(
  parameter int unsigned STACK_DEPTH = wos_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  wos_pkg::in_item_t   in_item,
  input  logic                out_valid,
  input  wos_pkg::out_item_t  out_item,
  output int                  fail_count,
  output int                  pending_count,
  output int                  model_depth,
  output int                  results_checked,
  output int                  peak_depth,
  output logic [4:0]          err_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import wos_pkg::*;

  localparam logic [63:0] AMOUNT_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam int          PRINT_CAP  = 30;

  // mirrored stack, entry 0 is the bottom
  logic [ENTRY_W-1:0] entries [STACK_DEPTH];
  int unsigned        fill;
  out_item_t          pending_results [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < PRINT_CAP)
      $display("%0t MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // apply one beat to the mirror and return the result it should produce
  function automatic out_item_t stack_apply(input in_item_t beat);
    out_item_t          res;
    logic [ENTRY_W-1:0] val;
    logic [ENTRY_W-1:0] tmp;
    int unsigned        top_idx;
    int unsigned        other_idx;
    int unsigned        pos;
    err_t               err;
    op_t                op;
    val = '0;
    err = ERR_OK;
    op  = op_t'(beat.opcode);
    pos = beat.position;
    case (op) inside
      OP_PUSH: begin
        if (fill >= STACK_DEPTH) begin
          err = ERR_OVER;
        end else begin
          entries[fill] = {beat.push_word3, beat.push_word2, beat.push_word1, beat.push_word0};
          fill++;
        end
      end
      OP_POP, OP_POP_ADDR, OP_POP_U64, OP_POP_AMOUNT: begin
        if (fill == 0) begin
          err = ERR_UNDER;
        end else begin
          fill--;
          val = entries[fill];
          // address keeps 160 bits; u64 and amount keep the low word, range checked
          if (op == OP_POP_ADDR) begin
            val[ENTRY_W-1:160] = '0;
          end else if (op == OP_POP_U64 || op == OP_POP_AMOUNT) begin
            if (val[ENTRY_W-1:64] != '0) err = ERR_LARGE;
            if (op == OP_POP_AMOUNT && val[63:0] > AMOUNT_MAX) err = ERR_LARGE;
            val[ENTRY_W-1:64] = '0;
          end
        end
      end
      OP_SWAP: begin
        if (pos >= fill) begin
          err = ERR_INDEX;
        end else begin
          top_idx   = fill - 1;
          other_idx = top_idx - pos;
          tmp                = entries[top_idx];
          entries[top_idx]   = entries[other_idx];
          entries[other_idx] = tmp;
        end
      end
      OP_DUP: begin
        if (pos >= fill) begin
          err = ERR_INDEX;
        end else if (fill >= STACK_DEPTH) begin
          err = ERR_OVER;
        end else begin
          entries[fill] = entries[fill - 1 - pos];
          fill++;
        end
      end
      default: ;
    endcase
    res.out_word0  = val[63:0];
    res.out_word1  = val[127:64];
    res.out_word2  = val[191:128];
    res.out_word3  = val[255:192];
    res.error_code = err;
    res.depth      = DEPTH_W'(fill);
    return res;
  endfunction

  // watch both channels on the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fill = 0;
      pending_results.delete();
      err_seen = '0;
    end else begin
      // result side first: a new beat cannot complete in the edge that takes it
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, depth", 64'(out_item.depth), 64'd0);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (out_item.out_word0 !== want.out_word0)
            report_mismatch("out_word0", out_item.out_word0, want.out_word0);
          if (out_item.out_word1 !== want.out_word1)
            report_mismatch("out_word1", out_item.out_word1, want.out_word1);
          if (out_item.out_word2 !== want.out_word2)
            report_mismatch("out_word2", out_item.out_word2, want.out_word2);
          if (out_item.out_word3 !== want.out_word3)
            report_mismatch("out_word3", out_item.out_word3, want.out_word3);
          if (out_item.error_code !== want.error_code)
            report_mismatch("error_code", 64'(out_item.error_code), 64'(want.error_code));
          if (out_item.depth !== want.depth)
            report_mismatch("depth", 64'(out_item.depth), 64'(want.depth));
          results_checked++;
        end
      end
      if (start && !busy) begin
        want = stack_apply(in_item);
        pending_results.push_back(want);
        err_seen[want.error_code] = 1'b1;
        if (fill > peak_depth) peak_depth = fill;
      end
    end
    pending_count = pending_results.size();
    model_depth   = fill;
  end

endmodule

/* bench/testbench.sv */
// Top of the word operand stack bench: clock, reset, directed and random command beats
// with sender idle phases, and the final verdict. Depends on wos_pkg, the
// word_operand_stack RTL and word_operand_stack_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wos_pkg::*;

  localparam int unsigned DEPTH        = STACK_DEPTH_DEF;
  localparam int          RANDOM_BEATS = 1800;
  localparam int          SETTLE_BEATS = 300;
  localparam int          FULL_EXTRA   = 25;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam logic [63:0] AMOUNT_MAX   = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef enum int { MIX_HOVER, MIX_GROW, MIX_DRAIN } mix_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  int         fail_count;
  int         pending_count;
  int         model_depth;
  int         results_checked;
  int         peak_depth;
  logic [4:0] err_seen;
  int         beats_sent;
  int         cycle_count;

  word_operand_stack #(.STACK_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  word_operand_stack_checker #(.STACK_DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .model_depth     (model_depth),
    .results_checked (results_checked),
    .peak_depth      (peak_depth),
    .err_seen        (err_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, pending_count);
      $display("testbench failed");
      $finish;
    end
  end

  function automatic in_item_t make_beat(input op_t op, input logic [255:0] val,
                                         input logic [POS_W-1:0] pos);
    in_item_t b;
    b.opcode     = op;
    b.push_word0 = val[63:0];
    b.push_word1 = val[127:64];
    b.push_word2 = val[191:128];
    b.push_word3 = val[255:192];
    b.position   = pos;
    return b;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // push data biased toward the range limits of the checked pops
  function automatic logic [255:0] pick_value();
    logic [255:0] v;
    v = {rand_word(), rand_word(), rand_word(), rand_word()};
    case ($urandom_range(0, 5))
      2: v[255:64] = '0;
      3: begin
        v[255:64] = '0;
        case ($urandom_range(0, 3))
          0: v[63:0] = AMOUNT_MAX;
          1: v[63:0] = AMOUNT_MAX + 64'd1;
          2: v[63:0] = '1;
          default: v[63:0] = '0;
        endcase
      end
      4: begin
        v[255:64] = '0;
        v[$urandom_range(64, 255)] = 1'b1;
      end
      5: v[255:192] = '0;
      default: ;
    endcase
    return v;
  endfunction

  // mostly a legal index, sometimes any index, zero, all ones or the first illegal one
  function automatic logic [POS_W-1:0] pick_position(input int depth);
    int r;
    r = $urandom_range(0, 99);
    if (depth > 0 && r < 80) return POS_W'($urandom_range(0, depth - 1));
    if (r < 90) return POS_W'($urandom);
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return POS_W'(depth);
    endcase
  endfunction

  function automatic in_item_t pick_beat(input mix_t mix, input int depth);
    int  w_push;
    int  w_dup;
    int  w_pop;
    int  w_swap;
    int  r;
    op_t op;
    case (mix)
      MIX_GROW:  begin w_push = 60; w_dup = 30; w_pop =  4; w_swap =  5; end
      MIX_DRAIN: begin w_push = 14; w_dup =  8; w_pop = 56; w_swap = 17; end
      default:   begin w_push = 26; w_dup = 12; w_pop = 40; w_swap = 17; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_push) op = OP_PUSH;
    else if (r < w_push + w_dup) op = OP_DUP;
    else if (r < w_push + w_dup + w_pop) op = op_t'($urandom_range(OP_POP, OP_POP_AMOUNT));
    else if (r < w_push + w_dup + w_pop + w_swap) op = OP_SWAP;
    else op = OP_NONE;
    return make_beat(op, pick_value(), pick_position(depth));
  endfunction

  // drive one beat after an optional idle gap and hold it until taken
  task automatic send_beat(input in_item_t beat, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  initial begin
    in_item_t     directed [$];
    logic [255:0] ones;
    int           idle_pct;
    int           gap;
    int           after_full;
    mix_t         mix;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    ones    = '1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty-stack errors, ignored opcode, range limits of checked pops,
    // swap with the top itself, out-of-range indexes
    directed.push_back(make_beat(OP_POP,        '0, '0));
    directed.push_back(make_beat(OP_POP_AMOUNT, '0, '0));
    directed.push_back(make_beat(OP_SWAP,       '0, '0));
    directed.push_back(make_beat(OP_DUP,        '0, '0));
    directed.push_back(make_beat(OP_NONE,       ones, '1));
    directed.push_back(make_beat(OP_PUSH,       ones, '1));
    directed.push_back(make_beat(OP_PUSH,       '0, '0));
    directed.push_back(make_beat(OP_POP_U64,    '0, '0));
    directed.push_back(make_beat(OP_PUSH,       256'h1 << 64, '0));
    directed.push_back(make_beat(OP_POP_U64,    '0, '0));
    directed.push_back(make_beat(OP_PUSH,       {192'h0, 64'hFFFF_FFFF_FFFF_FFFF}, '0));
    directed.push_back(make_beat(OP_POP_U64,    '0, '0));
    directed.push_back(make_beat(OP_PUSH,       {192'h0, AMOUNT_MAX}, '0));
    directed.push_back(make_beat(OP_POP_AMOUNT, '0, '0));
    directed.push_back(make_beat(OP_PUSH,       {192'h0, AMOUNT_MAX + 64'd1}, '0));
    directed.push_back(make_beat(OP_POP_AMOUNT, '0, '0));
    directed.push_back(make_beat(OP_PUSH,       '0, '0));
    directed.push_back(make_beat(OP_SWAP,       '0, '0));
    directed.push_back(make_beat(OP_SWAP,       '0, 10'd1));
    directed.push_back(make_beat(OP_SWAP,       '0, 10'd2));
    directed.push_back(make_beat(OP_DUP,        '0, 10'd1));
    directed.push_back(make_beat(OP_DUP,        '0, '1));
    directed.push_back(make_beat(OP_POP_ADDR,   '0, '0));
    directed.push_back(make_beat(OP_POP,        '0, '0));
    directed.push_back(make_beat(OP_POP,        '0, '0));
    foreach (directed[i]) send_beat(directed[i], 0);

    // random: hover near empty, then fill past full, then drain with mixed traffic
    after_full = 0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i < 450) idle_pct = 0;
      else if (i < 900) idle_pct = 61;
      else if (i < 1350) idle_pct = 0;
      else idle_pct = 8;
      if (i < SETTLE_BEATS) begin
        mix = MIX_HOVER;
      end else if (after_full < FULL_EXTRA) begin
        mix = MIX_GROW;
        if (model_depth >= DEPTH) after_full++;
      end else begin
        mix = MIX_DRAIN;
      end
      // each cycle the sender could drive, it stays idle with the phase's odds
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct) gap++;
      send_beat(pick_beat(mix, model_depth), gap);
    end
    @(negedge clk);
    start <= 1'b0;

    // drain outstanding results, then wait on for stray strobes
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d command beats sent, %0d results checked, stack peaked at %0d of %0d",
             beats_sent, results_checked, peak_depth, DEPTH);
    $display("error codes seen (bit per code, ok at bit 0): %b, mismatches: %0d",
             err_seen, fail_count);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
